### rtl/oase_pkg.sv
package oase_pkg;

  // fixed field widths
  localparam int unsigned CMD_W    = 4;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned WIDE_W   = 40;
  localparam int unsigned DIVD_W   = 48;
  localparam int unsigned STEP_W   = 6;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 168;

  localparam int unsigned CAPACITY_DEF = 64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 4'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SORT   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SUM    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_AVG    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MINMAX = 4'd8;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_ERR,
    S_INS_RD, S_INS_WR, S_INS_PUT,
    S_DEL_RD0, S_DEL_GET, S_DEL_RD, S_DEL_WR, S_DEL_PUT,
    S_CNT_RD, S_CNT_CHK, S_FND_RD, S_FND_CHK,
    S_DMP_RD, S_DMP_OUT,
    S_SRT_RA, S_SRT_RB, S_SRT_CMP, S_SRT_WB,
    S_ACC_RD, S_ACC_USE, S_DIV, S_DONE
  } state_e;

  // one result transaction
  typedef struct packed {
    logic              last;
    logic [CNT_W-1:0]  held;
    logic [WIDE_W-1:0] mean_q8;
    logic [WIDE_W-1:0] total;
    logic [SLOT_W-1:0] where;
    logic [WORD_W-1:0] upper_word;
    logic [WORD_W-1:0] word;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

### rtl/ordered_array_store_engine_top.sv
// Array store engine: keeps up to CAPACITY signed words in a memory with one read and one
// write port and runs one command at a time under a sequencer (append, insert, delete, search,
// dump, bubble sort, sum, Q8 average, min/max). Every memory visit is a read step and a use
// step; insert and delete visit memory once per shifted entry; search walks the elements twice,
// once to count matches and once to report them; sort makes n*(n-1)/2 compares and writes back
// the pair when it is swapped; the average adds a pass through the bit-serial divider. For a
// valid command the input is not ready until the command has delivered its final result into
// the output register, and each result waits there until taken.
module ordered_array_store_engine_top #(
  parameter int unsigned CAPACITY = oase_pkg::CAPACITY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // slot [6:0], operand [38:7], zero pad [39]
  input  logic [oase_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // command [3:0]
  input  logic [oase_pkg::CMD_W-1:0]       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // status [2:0], word [34:3], upper_word [66:35], where [73:67], total [113:74],
  // mean_q8 [153:114], held [160:154], zero pad [167:161]
  output logic [oase_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);
  import oase_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  state_e            state_q, state_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [WORD_W-1:0] opnd_q, opnd_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  hits_q, hits_d;
  logic [CNT_W-1:0]  seen_q, seen_d;
  logic [CNT_W-1:0]  lim_q, lim_d;
  logic [WORD_W-1:0] tmp_q, tmp_d;
  logic [WIDE_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [STAT_W-1:0] err_q, err_d;
  logic              ovalid_q, ovalid_d;
  res_t              out_q, out_d;
  res_t              res;
  logic              emit, can_emit;

  logic [WORD_W-1:0] store_mem [CAPACITY];
  logic [WORD_W-1:0] rdata_q;
  logic [CNT_W-1:0]  raddr;
  logic [CNT_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic              we;

  logic              div_start, div_done;
  logic [WIDE_W-1:0] div_quot;

  logic [CMD_W-1:0]  in_cmd;
  logic [SLOT_W-1:0] in_slot;
  logic [WORD_W-1:0] in_opnd;
  logic              match;

  assign in_cmd   = s_axis_tuser_i;
  assign in_slot  = s_axis_tdata_i[SLOT_W-1:0];
  assign in_opnd  = s_axis_tdata_i[SLOT_W+WORD_W-1:SLOT_W];
  assign can_emit = !ovalid_q || m_axis_tready_i;
  assign match    = rdata_q == opnd_q;

  // element memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_mem[waddr[AW-1:0]] <= wdata;
    end
    rdata_q <= store_mem[raddr[AW-1:0]];
  end

  // divider for the average
  oase_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({acc_d, 8'b0}),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    slot_d    = slot_q;
    opnd_d    = opnd_q;
    count_d   = count_q;
    idx_d     = idx_q;
    hits_d    = hits_q;
    seen_d    = seen_q;
    lim_d     = lim_q;
    tmp_d     = tmp_q;
    acc_d     = acc_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    err_d     = err_q;
    raddr     = idx_q;
    waddr     = idx_q;
    wdata     = rdata_q;
    we        = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    res       = '0;
    res.held  = count_q;
    res.last  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d  = in_cmd;
          slot_d = in_slot;
          opnd_d = in_opnd;
          idx_d  = '0;
          hits_d = '0;
          seen_d = '0;
          acc_d  = '0;
          if (in_cmd > CMD_MINMAX) begin
            state_d = S_IDLE;
          end else if (in_cmd == CMD_APPEND || in_cmd == CMD_INSERT) begin
            if (count_q >= CAP) begin
              err_d   = ST_FULL;
              state_d = S_ERR;
            end else if (in_cmd == CMD_INSERT && in_slot > count_q) begin
              err_d   = ST_INVALID;
              state_d = S_ERR;
            end else begin
              if (in_cmd == CMD_APPEND) begin
                slot_d = count_q;
              end
              idx_d   = count_q;
              state_d = (count_q > slot_d) ? S_INS_RD : S_INS_PUT;
            end
          end else if (count_q == '0) begin
            err_d   = ST_EMPTY;
            state_d = S_ERR;
          end else begin
            priority case (in_cmd)
              CMD_DELETE: begin
                if (in_slot >= count_q) begin
                  err_d   = ST_INVALID;
                  state_d = S_ERR;
                end else begin
                  idx_d   = in_slot;
                  state_d = S_DEL_RD0;
                end
              end
              CMD_SEARCH: state_d = S_CNT_RD;
              CMD_DUMP:   state_d = S_DMP_RD;
              CMD_SORT: begin
                lim_d   = count_q - CNT_W'(1);
                state_d = (count_q == CNT_W'(1)) ? S_DONE : S_SRT_RA;
              end
              default:    state_d = S_ACC_RD;
            endcase
          end
        end
      end

      S_ERR: begin
        if (can_emit) begin
          emit       = 1'b1;
          res.status = err_q;
          res.word   = (err_q == ST_NOTFOUND) ? opnd_q : '0;
          state_d    = S_IDLE;
        end
      end

      // insert: shift entries right from the top
      S_INS_RD: begin
        raddr   = idx_q - CNT_W'(1);
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        we      = 1'b1;
        idx_d   = idx_q - CNT_W'(1);
        state_d = (idx_d > slot_q) ? S_INS_RD : S_INS_PUT;
      end
      S_INS_PUT: begin
        if (can_emit) begin
          we        = 1'b1;
          waddr     = slot_q;
          wdata     = opnd_q;
          count_d   = count_q + CNT_W'(1);
          emit      = 1'b1;
          res.word  = opnd_q;
          res.where = slot_q;
          res.held  = count_d;
          state_d   = S_IDLE;
        end
      end

      // delete: capture the word, shift entries left
      S_DEL_RD0: state_d = S_DEL_GET;
      S_DEL_GET: begin
        tmp_d   = rdata_q;
        state_d = (idx_q + CNT_W'(1) < count_q) ? S_DEL_RD : S_DEL_PUT;
      end
      S_DEL_RD: begin
        raddr   = idx_q + CNT_W'(1);
        state_d = S_DEL_WR;
      end
      S_DEL_WR: begin
        we      = 1'b1;
        idx_d   = idx_q + CNT_W'(1);
        state_d = (idx_d + CNT_W'(1) < count_q) ? S_DEL_RD : S_DEL_PUT;
      end
      S_DEL_PUT: begin
        if (can_emit) begin
          count_d   = count_q - CNT_W'(1);
          emit      = 1'b1;
          res.word  = tmp_q;
          res.where = slot_q;
          res.held  = count_d;
          state_d   = S_IDLE;
        end
      end

      // search: count matches, then report them
      S_CNT_RD: state_d = S_CNT_CHK;
      S_CNT_CHK: begin
        hits_d = hits_q + CNT_W'(match);
        if (idx_q + CNT_W'(1) < count_q) begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_CNT_RD;
        end else if (hits_d == '0) begin
          err_d   = ST_NOTFOUND;
          state_d = S_ERR;
        end else begin
          idx_d   = '0;
          state_d = S_FND_RD;
        end
      end
      S_FND_RD: state_d = S_FND_CHK;
      S_FND_CHK: begin
        if (match) begin
          if (can_emit) begin
            emit      = 1'b1;
            res.word  = opnd_q;
            res.where = idx_q;
            seen_d    = seen_q + CNT_W'(1);
            res.last  = seen_d == hits_q;
            idx_d     = idx_q + CNT_W'(1);
            state_d   = (res.last || idx_d >= count_q) ? S_IDLE : S_FND_RD;
          end
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = (idx_d < count_q) ? S_FND_RD : S_IDLE;
        end
      end

      // dump every element
      S_DMP_RD: state_d = S_DMP_OUT;
      S_DMP_OUT: begin
        if (can_emit) begin
          emit      = 1'b1;
          res.word  = rdata_q;
          res.where = idx_q;
          idx_d     = idx_q + CNT_W'(1);
          res.last  = idx_d == count_q;
          state_d   = res.last ? S_IDLE : S_DMP_RD;
        end
      end

      // bubble sort, one compare and swap at a time
      S_SRT_RA: state_d = S_SRT_RB;
      S_SRT_RB: begin
        tmp_d   = rdata_q;
        raddr   = idx_q + CNT_W'(1);
        state_d = S_SRT_CMP;
      end
      S_SRT_CMP, S_SRT_WB: begin
        if (state_q == S_SRT_CMP && $signed(tmp_q) > $signed(rdata_q)) begin
          we      = 1'b1;
          state_d = S_SRT_WB;
        end else begin
          if (state_q == S_SRT_WB) begin
            we    = 1'b1;
            waddr = idx_q + CNT_W'(1);
            wdata = tmp_q;
          end
          if (idx_q + CNT_W'(1) < lim_q) begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_SRT_RA;
          end else if (lim_q == CNT_W'(1)) begin
            state_d = S_DONE;
          end else begin
            lim_d   = lim_q - CNT_W'(1);
            idx_d   = '0;
            state_d = S_SRT_RA;
          end
        end
      end

      // sum, min and max in one walk
      S_ACC_RD: state_d = S_ACC_USE;
      S_ACC_USE: begin
        acc_d = acc_q + {{(WIDE_W-WORD_W){rdata_q[WORD_W-1]}}, rdata_q};
        if (idx_q == '0 || $signed(rdata_q) < $signed(lo_q)) begin
          lo_d = rdata_q;
        end
        if (idx_q == '0 || $signed(rdata_q) > $signed(hi_q)) begin
          hi_d = rdata_q;
        end
        if (idx_q + CNT_W'(1) < count_q) begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_ACC_RD;
        end else if (cmd_q == CMD_AVG) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (can_emit) begin
          emit           = 1'b1;
          res.word       = (cmd_q == CMD_MINMAX) ? lo_q : '0;
          res.upper_word = (cmd_q == CMD_MINMAX) ? hi_q : '0;
          res.total      = (cmd_q == CMD_SUM) ? acc_q : '0;
          res.mean_q8    = (cmd_q == CMD_AVG) ? div_quot : '0;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    ovalid_d = emit || (ovalid_q && !m_axis_tready_i);
    out_d    = emit ? res : out_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    slot_q <= slot_d;
    opnd_q <= opnd_d;
    idx_q  <= idx_d;
    hits_q <= hits_d;
    seen_q <= seen_d;
    lim_q  <= lim_d;
    tmp_q  <= tmp_d;
    acc_q  <= acc_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    err_q  <= err_d;
    out_q  <= out_d;
  end

  // ports
  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-$bits(res_t)+1){1'b0}},
                            out_q.held, out_q.mean_q8, out_q.total, out_q.where,
                            out_q.upper_word, out_q.word, out_q.status};

  // checks
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP) else $error("element count above capacity");
  a_div_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cmd_q == CMD_AVG) else $error("divider used outside average");
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC_USE || state_q == S_DMP_OUT) |-> idx_q < count_q)
    else $error("walk index past count");
  a_seen_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FND_CHK |-> seen_q < hits_q) else $error("search reported too many hits");

endmodule

### rtl/oase_div.sv
module oase_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [oase_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [oase_pkg::CNT_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [oase_pkg::WIDE_W-1:0]   quot_o
);
  import oase_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [DIVD_W-1:0] dq_q;
  logic              neg_q;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W:0]    rem_nx;
  logic [DIVD_W-1:0] mag;

  // one restoring step per cycle while busy
  assign rem_sh = {rem_q, dq_q[DIVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
  assign mag    = dividend_i[DIVD_W-1] ? -dividend_i : dividend_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= mag;
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[DIVD_W-1];
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIVD_W-2:0], ge};
      rem_q <= rem_nx[CNT_W-1:0];
    end
  end

  // sign restored, truncated toward zero
  logic [DIVD_W-1:0] q_signed;
  assign q_signed = neg_q ? -dq_q : dq_q;
  assign quot_o   = q_signed[WIDE_W-1:0];
  assign done_o   = done_q;

endmodule
